// ----- rtl/sfr_pkg.sv -----
// Shared types and constants for the stream find-and-replace block.
package sfr_pkg;

   localparam int MAX_PATTERN = 8;
   localparam int REPL_MAX    = 8;
   localparam int BYTE_W      = 8;
   localparam int STR_W       = 64;
   localparam int LEN_W       = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int WIN_IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int BEAT_CNT_W  = 3;   // results per item minus one, up to eight results
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEARCH_BYTES  = 2'd0,
      CSR_SEARCH_LEN    = 2'd1,
      CSR_REPLACE_BYTES = 2'd2,
      CSR_REPLACE_LEN   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              in_last;
   } req_beat_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic              out_last;
   } rsp_beat_type;

   typedef struct packed {
      logic [STR_W-1:0] search_bytes;
      logic [LEN_W-1:0] search_len;
      logic [STR_W-1:0] replace_bytes;
      logic [LEN_W-1:0] replace_len;
   } cfg_type;

   // One burst of result beats produced by a single input beat.
   typedef struct packed {
      logic [STR_W-1:0]      data;
      logic [BEAT_CNT_W-1:0] cnt_m1;
      logic                  last;
      logic                  bare;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

// ----- rtl/sfr_front.sv -----
// Front end: pending window, pattern compare and burst classification.
module sfr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  sfr_pkg::req_beat_type req_data,
   input  sfr_pkg::cfg_type     cfg,
   output logic                 cmd_valid,
   output sfr_pkg::cmd_type     cmd
);
   import sfr_pkg::*;

   logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_ff, win_in;
   logic [LEN_W-1:0]                   count_ff, count_in;

   logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_app;
   logic [LEN_W-1:0]                   len_eff, rlen_eff, cnt1, pop_n, shift_n;
   logic                               stale, match;
   logic [MAX_PATTERN-1:0]             eq;
   logic [MAX_PATTERN*BYTE_W-1:0]      win_shifted;

   always_comb begin
      if (cfg.search_len == '0) begin
         len_eff = LEN_W'(1);
      end else if (cfg.search_len > LEN_W'(MAX_PATTERN)) begin
         len_eff = LEN_W'(MAX_PATTERN);
      end else begin
         len_eff = cfg.search_len;
      end
      rlen_eff = (cfg.replace_len > LEN_W'(REPL_MAX)) ? LEN_W'(REPL_MAX) : cfg.replace_len;
   end

   // the count never reaches the window depth between beats, so the append always lands
   always_comb begin
      win_app = win_ff;
      win_app[count_ff[WIN_IDX_W-1:0]] = req_data.in_byte;
   end

   assign cnt1  = count_ff + LEN_W'(1);
   assign stale = cnt1 > len_eff;

   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         eq[i] = (LEN_W'(i) >= len_eff) ||
                 (win_app[i] == cfg.search_bytes[i*BYTE_W +: BYTE_W]);
      end
   end

   assign match       = !stale && (cnt1 == len_eff) && (&eq);
   assign pop_n       = cnt1 - len_eff;
   assign win_shifted = win_app >> {shift_n, 3'b000};
   assign win_in      = win_shifted;

   always_comb begin
      cmd_valid   = 1'b0;
      cmd.data    = win_app;
      cmd.cnt_m1  = '0;
      cmd.last    = req_data.in_last;
      cmd.bare    = 1'b0;
      shift_n     = '0;
      count_in    = count_ff;
      if (match) begin
         count_in = '0;
         cmd.data = cfg.replace_bytes;
         if (rlen_eff != '0) begin
            cmd_valid  = 1'b1;
            cmd.cnt_m1 = BEAT_CNT_W'(rlen_eff - LEN_W'(1));
         end else if (req_data.in_last) begin
            // deleted match at end of text: bare end marker
            cmd_valid = 1'b1;
            cmd.bare  = 1'b1;
            cmd.data  = '0;
         end
      end else if (req_data.in_last) begin
         count_in   = '0;
         cmd_valid  = 1'b1;
         cmd.cnt_m1 = BEAT_CNT_W'(count_ff);
      end else if (stale) begin
         // search length shrank: drain down to exactly search length, no compare
         cmd_valid  = 1'b1;
         cmd.cnt_m1 = BEAT_CNT_W'(pop_n - LEN_W'(1));
         shift_n    = pop_n;
         count_in   = len_eff;
      end else if (cnt1 == len_eff) begin
         cmd_valid = 1'b1;
         shift_n   = LEN_W'(1);
         count_in  = len_eff - LEN_W'(1);
      end else begin
         count_in = cnt1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

endmodule

// ----- rtl/sfr_cmd_fifo.sv -----
// Short queue of result bursts between the front and back ends.
module sfr_cmd_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  sfr_pkg::cmd_type        push_data,
   input  logic                    pop,
   output sfr_pkg::cmd_type        pop_data,
   output sfr_pkg::fifo_status_type status
);
   import sfr_pkg::*;

   cmd_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]     fill_ff, fill_in;
   logic                    do_push, do_pop;

   assign status.full  = (fill_ff == (FIFO_PTR_W+1)'(FIFO_DEPTH));
   assign status.empty = (fill_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + (FIFO_PTR_W+1)'(do_push) - (FIFO_PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/sfr_back.sv -----
// Back end: expands queued bursts into result beats, one per cycle while the receiver keeps popping.
module sfr_back (
   input  logic                    clock,
   input  logic                    reset,
   input  sfr_pkg::fifo_status_type q_status,
   input  sfr_pkg::cmd_type        q_data,
   output logic                    q_pop,
   input  logic                    rsp_pop,
   output logic                    rsp_empty,
   output sfr_pkg::rsp_beat_type   rsp_data
);
   import sfr_pkg::*;

   cmd_type                 cur_ff, cur_in;
   logic [BEAT_CNT_W-1:0]   idx_ff, idx_in;
   logic                    busy_ff, busy_in;
   logic                    final_beat, taken;

   assign final_beat = (idx_ff == cur_ff.cnt_m1);
   assign taken      = busy_ff && rsp_pop;
   assign q_pop      = !q_status.empty && (!busy_ff || (taken && final_beat));

   assign rsp_empty           = !busy_ff;
   assign rsp_data.out_byte   = cur_ff.bare ? '0 : cur_ff.data[idx_ff*BYTE_W +: BYTE_W];
   assign rsp_data.byte_valid = !cur_ff.bare;
   assign rsp_data.out_last   = cur_ff.last && final_beat;

   always_comb begin
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (q_pop) begin
         cur_in  = q_data;
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (taken) begin
         if (final_beat) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + BEAT_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

// ----- rtl/stream_find_replace.sv -----
// Top level of the streaming find-and-replace block.
//
// Text enters one byte per beat on the req_ queue port (push/full) and leaves
// on the rsp_ queue port (empty/pop). Every leftmost, non-overlapping match of
// the search string is swapped for the replacement string; other bytes pass in
// order. in_last closes a text: the window is flushed and the final beat
// carries out_last. A deleted match at the end gives a bare end-marker beat.
// Registers are written on csr_ (we/index/wdata); the user must write them only
// while the block is idle; the block itself does not enforce it. One input beat
// per cycle is taken while the burst queue is not full. A beat that yields
// results has its burst written into the burst queue, then loaded into the back
// end's current-burst register, which offers its results on the rsp_ port. A
// burst of N results is offered as N beats; the four-entry burst queue absorbs
// that. If the receiver stalls, the head beat holds steady and the queue fills;
// then full goes high. Reset (synchronous) empties the window and the queue and
// loads the defaults: search length one, all bytes zero, no replacement.
module stream_find_replace (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  sfr_pkg::req_beat_type                  req_data,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output sfr_pkg::rsp_beat_type                  rsp_data,
   input  logic                                   csr_we,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [sfr_pkg::STR_W-1:0]              csr_wdata
);
   import sfr_pkg::*;

   cfg_type          cfg_ff;
   logic             accept;
   logic             cmd_valid;
   cmd_type          cmd, q_data;
   fifo_status_type  q_status;
   logic             q_pop;

   // register file; the length fields keep the low nibble of the write
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.search_bytes  <= '0;
         cfg_ff.search_len    <= LEN_W'(1);
         cfg_ff.replace_bytes <= '0;
         cfg_ff.replace_len   <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SEARCH_BYTES:  cfg_ff.search_bytes  <= csr_wdata;
            CSR_SEARCH_LEN:    cfg_ff.search_len    <= csr_wdata[LEN_W-1:0];
            CSR_REPLACE_BYTES: cfg_ff.replace_bytes <= csr_wdata;
            CSR_REPLACE_LEN:   cfg_ff.replace_len   <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // stall input whenever the burst queue is full, result or not
   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   sfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   sfr_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && cmd_valid),
      .push_data (cmd),
      .pop       (q_pop),
      .pop_data  (q_data),
      .status    (q_status)
   );

   sfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/sfr_checker.sv -----
// Port-level checks for the find-and-replace block, bound to the top level.
module sfr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_push,
   input logic                          req_full,
   input logic                          rsp_empty,
   input logic                          rsp_pop,
   input sfr_pkg::rsp_beat_type         rsp_data
);
   import sfr_pkg::*;

   // reset leaves nothing to deliver and room to accept
   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queue not clear after reset");

   // a beat without a character is only ever the closing marker
   a_bare_is_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.byte_valid) |-> (rsp_data.out_last && rsp_data.out_byte == '0))
      else $error("bare beat that is not an end marker");

   // a waiting beat holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("result beat changed while stalled");

   // nothing can be waiting the cycle after an idle, drained block resumes
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      ($past(rsp_empty) && rsp_empty && !$past(req_push) && !req_full) |=> rsp_empty)
      else $error("result appeared without input");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (.*);

// ----- bench/testbench.sv -----
// Self-checking bench for the streaming find-and-replace block.
`timescale 1ns / 100ps

module testbench;
   import sfr_pkg::*;

   // Directed rows are walked first; random phases stop once this many text bytes are in.
   localparam int BYTE_GOAL  = 360;
   // Settling allowance after the last due beat, with margin for beats still in flight.
   localparam int SETTLE_CYC = 8;

   typedef enum logic [0:0] {ROW_CFG, ROW_BEAT} row_kind_type;

   // One line of the directed script: a register write or a text beat. A pinned beat
   // carries its single result, typed in; the others are left to the predictor.
   typedef struct {
      row_kind_type  kind;
      csr_index_type reg_index;
      logic [63:0]   value;
      req_beat_type  beat;
      bit            pinned;
      rsp_beat_type  want;
   } script_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_push = 1'b0;
   logic          req_full;
   req_beat_type  req_data = '0;
   logic          rsp_empty;
   logic          rsp_pop = 1'b0;
   rsp_beat_type  rsp_data;
   logic          csr_we = 1'b0;
   csr_index_type csr_index = CSR_SEARCH_BYTES;
   logic [63:0]   csr_wdata = '0;

   // Pinned expectation travelling alongside the beat being offered.
   bit            pin_valid = 1'b0;
   rsp_beat_type  pin_beat = '0;

   // Idle percentages for each side, changed between phases.
   int            send_gap_pct = 28;
   int            take_gap_pct = 52;

   int            bytes_sent = 0;
   int            faults = 0;

   // Bench copy of the block: registers, pending window and the output still owed.
   logic [63:0]   pat_bytes = '0;
   logic [3:0]    pat_len = 4'd1;
   logic [63:0]   sub_bytes = '0;
   logic [3:0]    sub_len = 4'd0;
   logic [7:0]    window [MAX_PATTERN];
   int unsigned   held = 0;
   rsp_beat_type  fresh[$];
   rsp_beat_type  text_due[$];

   script_row_type script[$];

   stream_find_replace DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic void emit(logic [7:0] ch, logic valid, logic fin);
      rsp_beat_type r;
      r.out_byte   = ch;
      r.byte_valid = valid;
      r.out_last   = fin;
      fresh.push_back(r);
   endfunction

   function automatic logic [7:0] take_oldest();
      logic [7:0] ch;
      ch = window[0];
      for (int k = 1; k < held; k++) window[k-1] = window[k];
      held--;
      return ch;
   endfunction

   // Works out the beats that one text byte releases; leaves them in fresh.
   function automatic void predict_rewrite(req_beat_type d);
      int unsigned plen;
      int unsigned rlen;
      bit          stale;
      bit          hit;
      fresh.delete();
      // Out-of-range lengths are clamped: zero search acts as one, anything past eight as eight.
      plen = (pat_len == 0) ? 1 : (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
      rlen = (sub_len > REPL_MAX) ? REPL_MAX : sub_len;
      if (held < MAX_PATTERN) begin
         window[held] = d.in_byte;
         held++;
      end
      // Window longer than the search (length cut mid-text): drain, no match this beat.
      stale = held > plen;
      hit   = !stale && held == plen;
      if (hit) begin
         for (int i = 0; i < plen; i++) begin
            if (window[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
         end
      end
      if (hit) begin
         held = 0;
         for (int i = 0; i < rlen; i++)
            emit(sub_bytes[8*i +: 8], 1'b1, d.in_last && (i + 1 == rlen));
         // Deleted match closing the text: bare end marker.
         if (d.in_last && rlen == 0) emit(8'h00, 1'b0, 1'b1);
         return;
      end
      if (d.in_last) begin
         while (held > 0) begin
            logic [7:0] ch;
            ch = take_oldest();
            emit(ch, 1'b1, held == 0);
         end
         return;
      end
      while (held >= plen && held > 0) begin
         emit(take_oldest(), 1'b1, 1'b0);
         if (stale && held == plen) break;
      end
   endfunction

   function automatic void check_beat(rsp_beat_type got);
      rsp_beat_type want;
      if (text_due.size() == 0) begin
         $error("result beat with nothing due: out_byte %h byte_valid %b out_last %b",
                got.out_byte, got.byte_valid, got.out_last);
         faults++;
         return;
      end
      want = text_due.pop_front();
      if (got.out_byte !== want.out_byte) begin
         $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
         faults++;
      end
      if (got.byte_valid !== want.byte_valid) begin
         $error("byte_valid: expected %b, got %b", want.byte_valid, got.byte_valid);
         faults++;
      end
      if (got.out_last !== want.out_last) begin
         $error("out_last: expected %b, got %b", want.out_last, got.out_last);
         faults++;
      end
   endfunction

   // ---------------------------------------------------------------- monitor
   // Everything is sampled at the rising edge, before the block's own updates land.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_SEARCH_BYTES:  pat_bytes = csr_wdata;
               CSR_SEARCH_LEN:    pat_len   = csr_wdata[3:0];
               CSR_REPLACE_BYTES: sub_bytes = csr_wdata;
               CSR_REPLACE_LEN:   sub_len   = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (req_push && !req_full) begin
            predict_rewrite(req_data);
            if (pin_valid) text_due.push_back(pin_beat);
            else foreach (fresh[i]) text_due.push_back(fresh[i]);
         end
         if (rsp_pop && !rsp_empty) check_beat(rsp_data);
      end
   end

   // Receiver: pop offered at the falling edge, idling at the current rate.
   always @(negedge clock) begin
      rsp_pop <= !reset && ($urandom_range(99) >= take_gap_pct);
   end

   // ---------------------------------------------------------------- driver
   // All driver tasks start and finish on a falling edge.

   task automatic send_beat(req_beat_type d, bit pinned, rsp_beat_type want);
      while ($urandom_range(99) < send_gap_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push  <= 1'b1;
      req_data  <= d;
      pin_valid <= pinned;
      pin_beat  <= want;
      @(posedge clock);
      while (req_full) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Registers only change with nothing owed and the pipe given time to settle,
   // since a beat that releases nothing may still be in flight.
   task automatic write_reg(csr_index_type idx, logic [63:0] val);
      req_push <= 1'b0;
      while (text_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYC) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic script_row_type row_cfg(csr_index_type idx, logic [63:0] val);
      script_row_type r;
      r = '{kind: ROW_CFG, reg_index: idx, value: val, beat: '0, pinned: 1'b0, want: '0};
      return r;
   endfunction

   function automatic script_row_type row_beat(logic [7:0] ch, logic fin);
      script_row_type r;
      r = '{kind: ROW_BEAT, reg_index: CSR_SEARCH_BYTES, value: '0, beat: '0,
            pinned: 1'b0, want: '0};
      r.beat.in_byte = ch;
      r.beat.in_last = fin;
      return r;
   endfunction

   function automatic script_row_type row_pin(logic [7:0] ch, logic fin,
                                              logic [7:0] och, logic ov, logic ofin);
      script_row_type r;
      r = row_beat(ch, fin);
      r.pinned          = 1'b1;
      r.want.out_byte   = och;
      r.want.byte_valid = ov;
      r.want.out_last   = ofin;
      return r;
   endfunction

   initial begin
      logic [7:0]  text[$];
      logic [7:0]  a0;
      logic [7:0]  a1;
      logic [63:0] v;
      int          eff;
      int          cut;
      int          texts;
      bit          open_end;
      rsp_beat_type none;

      none = '0;
      script = '{
         // Defaults: search is a single 0x00, replacement empty.
         row_pin(8'h41, 1'b1, 8'h41, 1'b1, 1'b1),
         row_pin(8'h00, 1'b1, 8'h00, 1'b0, 1'b1),   // deleted match at end: bare marker
         row_pin(8'hFF, 1'b0, 8'hFF, 1'b1, 1'b0),
         row_pin(8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1),
         // "aab" -> "XY", fed "aaabc": overlap must not hide the match.
         row_cfg(CSR_SEARCH_BYTES,  64'h0000_0000_0062_6161),
         row_cfg(CSR_SEARCH_LEN,    64'd3),
         row_cfg(CSR_REPLACE_BYTES, 64'h0000_0000_0000_5958),
         row_cfg(CSR_REPLACE_LEN,   64'd2),
         row_beat(8'h61, 1'b0), row_beat(8'h61, 1'b0), row_beat(8'h61, 1'b0),
         row_beat(8'h62, 1'b0), row_beat(8'h63, 1'b1),
         // Replacement length above eight clamps to eight, all ones.
         row_cfg(CSR_REPLACE_BYTES, 64'hFFFF_FFFF_FFFF_FFFF),
         row_cfg(CSR_REPLACE_LEN,   64'hFFFF_FFFF_FFFF_FFFF),
         row_beat(8'h61, 1'b0), row_beat(8'h61, 1'b0), row_beat(8'h62, 1'b1),
         // Search length zero acts as one.
         row_cfg(CSR_SEARCH_LEN,    64'd0),
         row_beat(8'h61, 1'b1),
         // Search length twelve acts as eight: full window match.
         row_cfg(CSR_SEARCH_BYTES,  64'hFFFF_FFFF_FFFF_FFFF),
         row_cfg(CSR_SEARCH_LEN,    64'd12),
         row_beat(8'hFF, 1'b0), row_beat(8'hFF, 1'b0), row_beat(8'hFF, 1'b0),
         row_beat(8'hFF, 1'b0), row_beat(8'hFF, 1'b0), row_beat(8'hFF, 1'b0),
         row_beat(8'hFF, 1'b0), row_beat(8'hFF, 1'b1),
         // Search cut from eight to one with three bytes held: they drain on the next beat.
         row_cfg(CSR_SEARCH_LEN,    64'd8),
         row_beat(8'h01, 1'b0), row_beat(8'h02, 1'b0), row_beat(8'h03, 1'b0),
         row_cfg(CSR_SEARCH_LEN,    64'd1),
         row_beat(8'h04, 1'b0), row_beat(8'h05, 1'b1)
      };

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[r]) begin
         if (script[r].kind == ROW_CFG) write_reg(script[r].reg_index, script[r].value);
         else send_beat(script[r].beat, script[r].pinned, script[r].want);
      end

      // Random phases: fresh settings, then texts built mostly from pattern prefixes.
      while (bytes_sent < BYTE_GOAL) begin
         if (bytes_sent < 120) begin
            send_gap_pct = 28;
            take_gap_pct = 52;
         end else if (bytes_sent < 240) begin
            send_gap_pct = 52;
            take_gap_pct = 28;
         end else begin
            send_gap_pct = 0;
            take_gap_pct = 0;
         end

         a0 = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(255));
         a1 = ($urandom_range(7) == 0) ? 8'hFF : 8'($urandom_range(255));

         if ($urandom_range(3) != 0) begin
            case ($urandom_range(7))
               0: v = '0;
               1: v = '1;
               2: v = {$urandom, $urandom};
               default: begin
                  for (int k = 0; k < 8; k++) v[8*k +: 8] = $urandom_range(1) ? a1 : a0;
               end
            endcase
            write_reg(CSR_SEARCH_BYTES, v);
         end
         if ($urandom_range(3) != 0) begin
            // Upper bits are noise; only the low nibble counts.
            v = {$urandom, $urandom};
            v[3:0] = ($urandom_range(5) == 0) ? 4'($urandom_range(15)) :
                                                4'($urandom_range(1, 8));
            write_reg(CSR_SEARCH_LEN, v);
         end
         if ($urandom_range(3) != 0) begin
            case ($urandom_range(5))
               0: v = '0;
               1: v = '1;
               default: v = {$urandom, $urandom};
            endcase
            write_reg(CSR_REPLACE_BYTES, v);
         end
         if ($urandom_range(3) != 0) begin
            v = {$urandom, $urandom};
            v[3:0] = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) :
                                                4'($urandom_range(0, 8));
            write_reg(CSR_REPLACE_LEN, v);
         end

         eff   = (pat_len == 0) ? 1 : (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
         texts = $urandom_range(2, 5);
         for (int t = 0; t < texts; t++) begin
            text.delete();
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(1)) begin
                  // Whole pattern most of the time, else a prefix to tease partial matches.
                  cut = ($urandom_range(2) != 0) ? eff : $urandom_range(1, eff);
                  for (int k = 0; k < cut; k++) text.push_back(pat_bytes[8*k +: 8]);
               end else begin
                  repeat ($urandom_range(1, 3)) begin
                     if ($urandom_range(4) == 0) text.push_back(8'($urandom_range(255)));
                     else text.push_back($urandom_range(1) ? a0 : a1);
                  end
               end
            end
            // Occasionally leave the phase's final text open so the next settings
            // (maybe a shorter search) meet a part-filled window.
            open_end = (t == texts - 1) && ($urandom_range(3) == 0);
            foreach (text[k]) begin
               req_beat_type d;
               d.in_byte = text[k];
               d.in_last = (k == text.size() - 1) && !open_end;
               send_beat(d, 1'b0, none);
            end
         end
      end

      req_push <= 1'b0;
      while (text_due.size() != 0) @(negedge clock);
      repeat (4 * SETTLE_CYC) @(negedge clock);
      if (faults == 0) $display("PASS stream_find_replace");
      else $display("FAIL stream_find_replace");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #(2_000_000);
      $display("FAIL stream_find_replace");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/sfr_pkg.sv
rtl/sfr_front.sv
rtl/sfr_cmd_fifo.sv
rtl/sfr_back.sv
rtl/stream_find_replace.sv
rtl/sfr_checker.sv
bench/testbench.sv
